[rtl/escat_pkg.sv]
// Shared types and constants for the motor speed controller throttle sequencer.
// Used by escat_cfg, escat_core and esc_arming_throttle_ramp; no dependencies.
package escat_pkg;

  // item codes
  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_ARM     = 3'd1;
  localparam logic [2:0] MODE_DISARM  = 3'd2;
  localparam logic [2:0] MODE_FULL    = 3'd3;
  localparam logic [2:0] MODE_IDLE    = 3'd4;

  // arming machine state codes
  localparam logic [1:0] PH_DISARMED  = 2'd0;
  localparam logic [1:0] PH_ARMING    = 2'd1;
  localparam logic [1:0] PH_ARMED     = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_OFF_US    = 3'd0;
  localparam logic [2:0] CFG_ARM_US    = 3'd1;
  localparam logic [2:0] CFG_MAX_US    = 3'd2;
  localparam logic [2:0] CFG_ARM_PULSE = 3'd3;
  localparam logic [2:0] CFG_RATE_UP   = 3'd4;
  localparam logic [2:0] CFG_RATE_DN   = 3'd5;

  localparam logic [11:0] OFF_US_RST    = 12'd1000;
  localparam logic [11:0] ARM_US_RST    = 12'd1100;
  localparam logic [11:0] MAX_US_RST    = 12'd2000;
  localparam logic [15:0] ARM_PULSE_RST = 16'd2000;
  localparam logic [15:0] RATE_RST      = 16'd256;

  localparam logic [12:0] ARM_TOL       = 13'd20;
  localparam logic [12:0] FILTER_MARGIN = 13'd5;
  localparam logic [12:0] ACTIVE_MARGIN = 13'd10;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] dt_ms;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [11:0] throttle_us;
    logic [11:0] target_us;
    logic [1:0]  arm_state;
    logic        filter_enable;
    logic        weapon_active;
    logic        arm_led;
    logic        arm_failed;
    logic        throttle_changed;
  } out_t;

  typedef struct packed {
    logic [11:0] off_us;
    logic [11:0] arm_us;
    logic [11:0] max_us;
    logic [15:0] arm_pulse_ms;
    logic [15:0] rate_up;
    logic [15:0] rate_down;
  } cfg_t;

endpackage

[rtl/escat_cfg.sv]
// Configuration register file for the throttle sequencer.
// Depends on escat_pkg (cfg_t, register indexes, reset values).
module escat_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  output escat_pkg::cfg_t     cfg_o
);
  import escat_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OFF_US:    cfg_d.off_us       = cfg_wdata_i[11:0];
        CFG_ARM_US:    cfg_d.arm_us       = cfg_wdata_i[11:0];
        CFG_MAX_US:    cfg_d.max_us       = cfg_wdata_i[11:0];
        CFG_ARM_PULSE: cfg_d.arm_pulse_ms = cfg_wdata_i;
        CFG_RATE_UP:   cfg_d.rate_up      = cfg_wdata_i;
        CFG_RATE_DN:   cfg_d.rate_down    = cfg_wdata_i;
        default:       cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_us       <= OFF_US_RST;
      cfg_q.arm_us       <= ARM_US_RST;
      cfg_q.max_us       <= MAX_US_RST;
      cfg_q.arm_pulse_ms <= ARM_PULSE_RST;
      cfg_q.rate_up      <= RATE_RST;
      cfg_q.rate_down    <= RATE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/escat_core.sv]
// Arming machine, target selection and slew step; holds the sequencer state.
// Depends on escat_pkg (in_t, out_t, cfg_t, mode and state codes).
module escat_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  escat_pkg::in_t     item_i,
  input  escat_pkg::cfg_t    cfg_i,
  output escat_pkg::out_t    res_o
);
  import escat_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [31:0] start_q, start_d;
  logic [11:0] cur_q, cur_d;
  logic [11:0] tgt_q, tgt_d;
  logic        act_q, act_d;

  logic        is_tick;
  logic        slew_en;
  logic        failed;
  logic [31:0] elapsed;
  logic signed [12:0] diff;
  logic        in_tol;
  logic [31:0] product;
  logic [23:0] step_sz;
  logic [24:0] sum;
  logic [11:0] gap;
  logic [11:0] slewed;
  logic [11:0] clamped;

  assign is_tick = (item_i.mode == MODE_TICK);
  assign slew_en = is_tick && (item_i.dt_ms != 16'd0);
  assign elapsed = item_i.now_ms - start_q;
  assign diff    = $signed({1'b0, cur_q}) - $signed({1'b0, cfg_i.arm_us});
  assign in_tol  = (diff >= -$signed(ARM_TOL)) && (diff <= $signed(ARM_TOL));

  // arming machine and target
  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    tgt_d   = tgt_q;
    act_d   = act_q;
    failed  = 1'b0;
    unique case (item_i.mode)
      MODE_ARM: begin
        if (phase_q == PH_DISARMED) begin
          phase_d = PH_ARMING;
          start_d = item_i.now_ms;
          tgt_d   = cfg_i.arm_us;
        end
      end
      MODE_DISARM: begin
        phase_d = PH_DISARMED;
        tgt_d   = cfg_i.off_us;
        act_d   = 1'b0;
      end
      MODE_FULL: begin
        if (phase_q == PH_ARMED) tgt_d = cfg_i.max_us;
      end
      MODE_IDLE: begin
        if (phase_q == PH_ARMED) tgt_d = cfg_i.arm_us;
      end
      MODE_TICK: begin
        if (phase_q == PH_ARMING && elapsed >= {16'd0, cfg_i.arm_pulse_ms}) begin
          if (in_tol) begin
            phase_d = PH_ARMED;
            tgt_d   = cfg_i.arm_us;
          end else begin
            phase_d = PH_DISARMED;
            tgt_d   = cfg_i.off_us;
            act_d   = 1'b0;
            failed  = 1'b1;
          end
        end
        if (item_i.dt_ms != 16'd0) begin
          act_d = (phase_d == PH_ARMED) &&
                  ({1'b0, tgt_d} > {1'b0, cfg_i.arm_us} + ACTIVE_MARGIN);
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // slew toward the target, step = floor(rate * dt / 256), never past target
  assign product = (tgt_d > cur_q) ? {16'd0, cfg_i.rate_up} * {16'd0, item_i.dt_ms}
                                   : {16'd0, cfg_i.rate_down} * {16'd0, item_i.dt_ms};
  assign step_sz = product[31:8];
  assign sum     = {13'd0, cur_q} + {1'b0, step_sz};
  assign gap     = cur_q - tgt_d;

  always_comb begin
    if (tgt_d > cur_q) begin
      slewed = (sum > {13'd0, tgt_d}) ? tgt_d : sum[11:0];
    end else if (cur_q > tgt_d) begin
      slewed = ({12'd0, gap} <= step_sz) ? tgt_d : cur_q - step_sz[11:0];
    end else begin
      slewed = cur_q;
    end
    clamped = slewed;
    if (clamped < cfg_i.off_us) clamped = cfg_i.off_us;
    if (clamped > cfg_i.max_us) clamped = cfg_i.max_us;
  end

  assign cur_d = slew_en ? clamped : cur_q;

  always_comb begin
    res_o.throttle_us      = cur_d;
    res_o.target_us        = tgt_d;
    res_o.arm_state        = phase_d;
    res_o.filter_enable    = slew_en && (phase_d == PH_ARMED) &&
                             ({1'b0, cur_d} > {1'b0, cfg_i.arm_us} + FILTER_MARGIN);
    res_o.weapon_active    = act_d;
    res_o.arm_led          = (phase_d != PH_DISARMED);
    res_o.arm_failed       = failed;
    res_o.throttle_changed = slew_en && (cur_d != cur_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DISARMED;
      start_q <= 32'd0;
      cur_q   <= OFF_US_RST;
      tgt_q   <= OFF_US_RST;
      act_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      start_q <= start_d;
      cur_q   <= cur_d;
      tgt_q   <= tgt_d;
      act_q   <= act_d;
    end
  end

  a_fail_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.arm_failed |-> phase_d == PH_DISARMED && tgt_d == cfg_i.off_us)
    else $error("failed arming check did not disarm");

  a_flags_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res_o.throttle_changed || res_o.filter_enable || res_o.arm_failed)
    |-> item_i.mode == MODE_TICK)
    else $error("tick-only flag raised on a command");

  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && slew_en && cfg_i.off_us <= cfg_i.max_us
    |-> cur_d >= cfg_i.off_us && cur_d <= cfg_i.max_us)
    else $error("throttle outside off..max after slew");

  a_width_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(cur_q) && $stable(phase_q))
    else $error("state changed without a transfer");

endmodule

[rtl/esc_arming_throttle_ramp.sv]
// Top level of the motor speed controller throttle sequencer.
// Depends on escat_pkg, escat_cfg and escat_core.

// One input item is taken per clock cycle while the output is not stalled,
// and each item gives exactly one result: an input register holds the item,
// the core computes the arming step, target and one slew multiply (rate x dt)
// combinationally from that register and the held state, and the result
// register presents it. A result waiting on a stalled output still lets one
// more item into an empty input register; after that in_stall_o stays high
// until the result is taken. Configuration
// registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i and should be
// changed only while no item is in flight; writes to indexes six and seven
// are ignored.
module esc_arming_throttle_ramp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  escat_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output escat_pkg::out_t   out_data_o
);
  import escat_pkg::*;

  cfg_t cfg;
  in_t  item_q;
  logic item_vld_q;
  out_t res;
  out_t res_q;
  logic res_vld_q;
  logic res_free;
  logic advance;
  logic in_xfer;

  escat_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // result register can take a new value when empty or being drained
  assign res_free   = !res_vld_q || !out_stall_i;
  assign advance    = item_vld_q && res_free;
  assign in_stall_o = item_vld_q && !res_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  escat_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (!in_stall_o) item_vld_q <= in_valid_i;
      if (res_free)    res_vld_q  <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) item_q <= in_data_i;
    if (advance) res_q  <= res;
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && out_stall_i |-> !advance)
    else $error("pending result overwritten");

  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && !advance |=> item_vld_q && $stable(item_q))
    else $error("held item lost before processing");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_vld_q)
    else $error("processed item produced no result");

endmodule

[tb/esc_arming_throttle_ramp_check.sv]
// Checker for the throttle sequencer: snoops the config port and both channels,
// predicts every result and compares it. Depends on escat_pkg.
module esc_arming_throttle_ramp_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  escat_pkg::in_t    in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  escat_pkg::out_t   out_data_i,
  output int                mismatches_o,
  output int                outstanding_o
);
  import escat_pkg::*;

  cfg_t        regs;
  logic [1:0]  phase;
  logic [31:0] arm_start_ms;
  logic [11:0] cur_width;
  logic [11:0] tgt_width;
  logic        active;

  out_t due_results[$];
  out_t want;
  out_t got_next;

  function automatic void drop_arming();
    phase     = PH_DISARMED;
    tgt_width = regs.off_us;
    active    = 1'b0;
  endfunction

  // Advances the held state by one item and returns the result it produces.
  function automatic out_t sequencer_step(in_t item);
    out_t        res;
    int          cur;
    int          tgt;
    int          offset;
    logic [31:0] elapsed;
    logic [31:0] prod;
    logic [11:0] prev_width;
    logic        filt;
    logic        failed;
    logic        changed;
    filt    = 1'b0;
    failed  = 1'b0;
    changed = 1'b0;
    case (item.mode)
      MODE_ARM: begin
        if (phase == PH_DISARMED) begin
          phase        = PH_ARMING;
          arm_start_ms = item.now_ms;
          tgt_width    = regs.arm_us;
        end
      end
      MODE_DISARM: drop_arming();
      MODE_FULL: begin
        if (phase == PH_ARMED) tgt_width = regs.max_us;
      end
      MODE_IDLE: begin
        if (phase == PH_ARMED) tgt_width = regs.arm_us;
      end
      MODE_TICK: begin
        if (phase == PH_ARMING) begin
          elapsed = item.now_ms - arm_start_ms;   // wraps mod 2^32
          if (elapsed >= {16'd0, regs.arm_pulse_ms}) begin
            offset = int'(cur_width) - int'(regs.arm_us);
            if (offset >= -int'(ARM_TOL) && offset <= int'(ARM_TOL)) begin
              phase     = PH_ARMED;
              tgt_width = regs.arm_us;
            end else begin
              drop_arming();
              failed = 1'b1;
            end
          end
        end
        if (item.dt_ms != 16'd0) begin
          cur        = int'(cur_width);
          tgt        = int'(tgt_width);
          prev_width = cur_width;
          if (cur < tgt) begin
            prod = {16'd0, regs.rate_up} * {16'd0, item.dt_ms};
            cur  = cur + int'(prod >> 8);
            if (cur > tgt) cur = tgt;
          end else if (cur > tgt) begin
            prod = {16'd0, regs.rate_down} * {16'd0, item.dt_ms};
            cur  = cur - int'(prod >> 8);
            if (cur < tgt) cur = tgt;
          end
          // max wins when the off level sits above it
          if (cur < int'(regs.off_us)) cur = int'(regs.off_us);
          if (cur > int'(regs.max_us)) cur = int'(regs.max_us);
          cur_width = cur[11:0];
          changed   = (cur_width != prev_width);
          filt      = (phase == PH_ARMED) &&
                      (int'(cur_width) > int'(regs.arm_us) + int'(FILTER_MARGIN));
          active    = (phase == PH_ARMED) &&
                      (int'(tgt_width) > int'(regs.arm_us) + int'(ACTIVE_MARGIN));
        end
      end
      default: ;  // spare modes leave everything alone
    endcase
    res.throttle_us      = cur_width;
    res.target_us        = tgt_width;
    res.arm_state        = phase;
    res.filter_enable    = filt;
    res.weapon_active    = active;
    res.arm_led          = (phase != PH_DISARMED);
    res.arm_failed       = failed;
    res.throttle_changed = changed;
    return res;
  endfunction

  task automatic compare_field(string name, logic [11:0] exp_val, logic [11:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      mismatches_o = mismatches_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.off_us       = OFF_US_RST;
      regs.arm_us       = ARM_US_RST;
      regs.max_us       = MAX_US_RST;
      regs.arm_pulse_ms = ARM_PULSE_RST;
      regs.rate_up      = RATE_RST;
      regs.rate_down    = RATE_RST;
      phase             = PH_DISARMED;
      arm_start_ms      = '0;
      cur_width         = OFF_US_RST;
      tgt_width         = OFF_US_RST;
      active            = 1'b0;
      due_results.delete();
      mismatches_o      = 0;
      outstanding_o     = 0;
    end else begin
      // retire before predicting so a result can never match its own transfer
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got %h", $time, out_data_i);
          mismatches_o = mismatches_o + 1;
        end else begin
          want = due_results.pop_front();
          compare_field("throttle_us", want.throttle_us, out_data_i.throttle_us);
          compare_field("target_us", want.target_us, out_data_i.target_us);
          compare_field("arm_state", 12'(want.arm_state), 12'(out_data_i.arm_state));
          compare_field("filter_enable", 12'(want.filter_enable),
                        12'(out_data_i.filter_enable));
          compare_field("weapon_active", 12'(want.weapon_active),
                        12'(out_data_i.weapon_active));
          compare_field("arm_led", 12'(want.arm_led), 12'(out_data_i.arm_led));
          compare_field("arm_failed", 12'(want.arm_failed), 12'(out_data_i.arm_failed));
          compare_field("throttle_changed", 12'(want.throttle_changed),
                        12'(out_data_i.throttle_changed));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        got_next = sequencer_step(in_data_i);
        due_results.push_back(got_next);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OFF_US:    regs.off_us       = cfg_wdata_i[11:0];
          CFG_ARM_US:    regs.arm_us       = cfg_wdata_i[11:0];
          CFG_MAX_US:    regs.max_us       = cfg_wdata_i[11:0];
          CFG_ARM_PULSE: regs.arm_pulse_ms = cfg_wdata_i;
          CFG_RATE_UP:   regs.rate_up      = cfg_wdata_i;
          CFG_RATE_DN:   regs.rate_down    = cfg_wdata_i;
          default: ;
        endcase
      end
      outstanding_o = due_results.size();
    end
  end

endmodule

[tb/esc_arming_throttle_ramp_tb.sv]
// Testbench top for the throttle sequencer: clock, reset, stimulus and verdict.
// Depends on escat_pkg, esc_arming_throttle_ramp and esc_arming_throttle_ramp_check.
module esc_arming_throttle_ramp_tb;
  import escat_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = CFG_OFF_US;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;

  int          mismatches;
  int          outstanding;
  int          quiet_cycles = 0;
  int          burst_left   = 0;
  int          stall_span   = 0;
  int          stall_pct    = 0;
  logic [31:0] clock_ms;

  esc_arming_throttle_ramp DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  esc_arming_throttle_ramp_check throttle_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: segments of random length, each with its own stall density
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_span = $urandom_range(200, 20);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_span = stall_span - 1;
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // no transfer on either channel for too long means the block hung
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic in_t make_item(logic [2:0] mode, logic [15:0] dt, logic [31:0] now);
    in_t it;
    it.mode   = mode;
    it.dt_ms  = dt;
    it.now_ms = now;
    return it;
  endfunction

  task automatic send_item(in_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(60, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
  endtask

  task automatic load_settings(cfg_t s);
    logic [15:0] pad;
    pad = 16'($urandom);   // upper bits of the narrow registers must be dropped
    drain();
    write_reg(CFG_OFF_US, {pad[15:12], s.off_us});
    write_reg(CFG_ARM_US, {pad[11:8], s.arm_us});
    write_reg(CFG_MAX_US, {pad[7:4], s.max_us});
    write_reg(CFG_ARM_PULSE, s.arm_pulse_ms);
    write_reg(CFG_RATE_UP, s.rate_up);
    write_reg(CFG_RATE_DN, s.rate_down);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t pick_settings(int k);
    cfg_t s;
    s.off_us       = 12'($urandom_range(1100, 900));
    s.arm_us       = s.off_us + 12'($urandom_range(200));
    s.max_us       = s.arm_us + 12'($urandom_range(1500));
    s.arm_pulse_ms = 16'($urandom_range(500));
    s.rate_up      = 16'($urandom_range(4096, 1));
    s.rate_down    = 16'($urandom_range(4096, 1));
    case (k)
      0: begin
        s.off_us    = OFF_US_RST;
        s.arm_us    = ARM_US_RST;
        s.max_us    = MAX_US_RST;
        s.rate_up   = RATE_RST;
        s.rate_down = RATE_RST;
      end
      1: s = '0;
      2: s = '1;
      3: begin
        s.off_us       = 12'd3000;
        s.arm_us       = 12'd1500;
        s.max_us       = 12'd1200;
        s.arm_pulse_ms = 16'd10;
        s.rate_up      = 16'hFFFF;
        s.rate_down    = 16'd1;
      end
      4: s.arm_pulse_ms = '0;
      8: begin
        s.off_us       = 12'($urandom);
        s.arm_us       = 12'($urandom);
        s.max_us       = 12'($urandom);
        s.arm_pulse_ms = 16'($urandom);
        s.rate_up      = 16'($urandom);
        s.rate_down    = 16'($urandom);
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [15:0] pick_dt();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return '0;
    if (r < 50) return 16'($urandom_range(20, 1));
    if (r < 90) return 16'($urandom_range(600, 21));
    if (r < 97) return 16'($urandom_range(65535, 601));
    return 16'hFFFF;
  endfunction

  // Mostly a coherent session with a running ms clock; a tenth is raw noise.
  task automatic run_traffic(int count);
    in_t item;
    int  pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      item.dt_ms = 16'($urandom);
      if (pick < 10) begin
        item.mode   = 3'($urandom);
        item.now_ms = $urandom;
      end else begin
        if (pick < 60) begin
          item.mode  = MODE_TICK;
          item.dt_ms = pick_dt();
          clock_ms   = clock_ms + 32'(item.dt_ms);
        end else if (pick < 70) begin
          item.mode = MODE_ARM;
        end else if (pick < 78) begin
          item.mode = MODE_FULL;
        end else if (pick < 86) begin
          item.mode = MODE_IDLE;
        end else if (pick < 91) begin
          item.mode = MODE_DISARM;
        end else begin
          item.mode  = MODE_TICK;
          item.dt_ms = '0;
          clock_ms   = clock_ms + $urandom_range(3);
        end
        clock_ms    = clock_ms + $urandom_range(2);
        item.now_ms = clock_ms;
      end
      send_item(item);
    end
  endtask

  // reset settings: off 1000, arm 1100, max 2000, pulse 2000, rates 1 us/ms
  task automatic run_directed();
    send_item(make_item(MODE_TICK, 16'd0, 32'd0));
    send_item(make_item(MODE_FULL, 16'hFFFF, 32'hFFFF_FFFF));  // not armed
    // spare modes five to seven, stops when the 3-bit count wraps
    for (logic [2:0] m = MODE_IDLE + 3'd1; m != MODE_TICK; m++) begin
      send_item(make_item(m, 16'hFFFF, 32'hFFFF_FFFF));
    end
    // pulse check across the 2^32 wrap, width still at off -> fault
    send_item(make_item(MODE_ARM, 16'd0, 32'hFFFF_FF00));
    send_item(make_item(MODE_ARM, 16'd0, 32'd0));
    send_item(make_item(MODE_TICK, 16'd0, 32'h0000_0900));
    // clean arm, full throttle, idle, disarm
    send_item(make_item(MODE_ARM, 16'd0, 32'd100));
    send_item(make_item(MODE_TICK, 16'd150, 32'd250));
    send_item(make_item(MODE_TICK, 16'd1, 32'd2100));
    send_item(make_item(MODE_FULL, 16'd0, 32'd2101));
    send_item(make_item(MODE_TICK, 16'd0, 32'd2102));
    send_item(make_item(MODE_TICK, 16'd500, 32'd2600));
    send_item(make_item(MODE_TICK, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(make_item(MODE_IDLE, 16'd0, 32'd0));
    send_item(make_item(MODE_TICK, 16'd3, 32'd3));
    send_item(make_item(MODE_TICK, 16'd0, 32'd4));
    send_item(make_item(MODE_DISARM, 16'hFFFF, 32'd5));
    send_item(make_item(MODE_TICK, 16'hFFFF, 32'd6));
    // tolerance edges: exactly 20 below passes, 21 below faults
    send_item(make_item(MODE_ARM, 16'hFFFF, 32'd0));
    send_item(make_item(MODE_TICK, 16'd80, 32'd10));
    send_item(make_item(MODE_TICK, 16'd0, 32'd2000));
    send_item(make_item(MODE_DISARM, 16'd0, 32'd2001));
    send_item(make_item(MODE_TICK, 16'd1, 32'd2001));
    send_item(make_item(MODE_ARM, 16'd0, 32'd3000));
    send_item(make_item(MODE_TICK, 16'd0, 32'd4999));
    send_item(make_item(MODE_TICK, 16'd0, 32'd5000));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    clock_ms = $urandom;
    run_directed();
    for (int k = 0; k < 9; k++) begin
      load_settings(pick_settings(k));
      if (k == 6) clock_ms = 32'hFFFF_F000;   // session clock rolls over
      run_traffic(205);
    end
    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
